/* hdl/dbes_pkg.sv */
// shared types and constants of the dual buffer ethernet service block
`default_nettype none
package dbes_pkg;

  // receive and transmit buffers are this many bytes long
  localparam int BUFFER_BYTES = 2048;

  localparam logic [15:0] RX_ERR_BITS    = 16'hA800;  // fcs, range, framing
  localparam logic [10:0] RX_HEAD        = 11'd2;
  localparam logic [10:0] RX_OVERHEAD    = 11'd20;
  localparam logic [10:0] RX_MAX_OFF     = 11'(BUFFER_BYTES - 2);
  localparam logic [11:0] TX_BUF_BYTES   = 12'(BUFFER_BYTES);
  localparam logic [7:0]  SLOT_TIME_RST  = 8'd51;
  localparam logic [10:0] MAX_TX_OFF_RST = 11'(BUFFER_BYTES - 512);
  localparam logic [15:0] MASK_ALL_ONES  = 16'hFFFF;

  // configuration register indexes
  localparam logic CFG_SLOT_TIME     = 1'b0;
  localparam logic CFG_MAX_TX_OFFSET = 1'b1;

  // result slots of one job, in emission order
  localparam int SLOT_RX0   = 0;
  localparam int SLOT_RX1   = 1;
  localparam int SLOT_TXEV  = 2;
  localparam int SLOT_START = 3;
  localparam int NUM_SLOTS  = 4;

  typedef enum logic [2:0] {
    KIND_RX_GOOD    = 3'd0,
    KIND_RX_ERROR   = 3'd1,
    KIND_RX_EMPTY   = 3'd2,
    KIND_TX_DONE    = 3'd3,
    KIND_TX_RETRY   = 3'd4,
    KIND_TX_DROPPED = 3'd5,
    KIND_TX_STARTED = 3'd6
  } kind_t;

  typedef struct packed {
    logic        command;
    logic        a_ether_owned;
    logic        b_ether_owned;
    logic        b_older;
    logic        jam_seen;
    logic        tx_ether_owned;
    logic [15:0] status_a;
    logic [15:0] status_b;
    logic [15:0] time_low;
    logic        queue_pending;
    logic [11:0] tx_length;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic        buffer_id;
    logic [10:0] rx_length;
    logic [15:0] backoff_value;
    logic [10:0] tx_offset;
    logic        pad_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic        buffer_id;
    logic [10:0] rx_length;
  } rx_slot_t;

  // one classified item, handed from front to back
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    rx_slot_t             rx0;
    rx_slot_t             rx1;
    kind_t                tx_kind;
    logic [15:0]          delay;
    logic [10:0]          tx_offset;
    logic                 pad_byte;
  } job_t;

endpackage
`default_nettype wire

/* hdl/dbes_front.sv */
// front end: accepts items, updates transmit state and classifies results
`default_nettype none
module dbes_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  dbes_pkg::in_item_t   in_data,
  input  wire                  q_full,
  input  wire  [10:0]          max_tx_offset,
  output logic                 push,
  output dbes_pkg::job_t       job
);
  import dbes_pkg::*;

  logic        tx_active_r, tx_active_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic        accept;
  logic [11:0] len_sat;
  logic [11:0] off_full;
  logic [10:0] off_clamp;
  logic [15:0] mask_shift;

  function automatic rx_slot_t rx_serve(input logic [15:0] status, input logic buf_id);
    rx_slot_t    r;
    logic [10:0] off;
    off = status[10:0];
    r.buffer_id = buf_id;
    if ((status & RX_ERR_BITS) != 16'd0 || off <= RX_HEAD || off > RX_MAX_OFF ||
        off <= RX_OVERHEAD) begin
      r.kind      = KIND_RX_ERROR;
      r.rx_length = 11'd0;
    end else begin
      r.kind      = KIND_RX_GOOD;
      r.rx_length = off - RX_OVERHEAD;
    end
    return r;
  endfunction

  assign accept = in_valid && !q_full;

  // start offset of a new frame
  always_comb begin
    len_sat   = (in_data.tx_length > TX_BUF_BYTES) ? TX_BUF_BYTES : in_data.tx_length;
    off_full  = TX_BUF_BYTES - len_sat;
    off_clamp = (off_full > {1'b0, max_tx_offset}) ? max_tx_offset : off_full[10:0];
  end

  assign mask_shift = {mask_r[14:0], 1'b0};

  always_comb begin
    tx_active_nxt = tx_active_r;
    mask_nxt      = mask_r;
    job           = '0;
    job.rx0       = '{kind: KIND_RX_EMPTY, buffer_id: 1'b0, rx_length: 11'd0};
    job.rx1       = '{kind: KIND_RX_EMPTY, buffer_id: 1'b0, rx_length: 11'd0};
    job.tx_kind   = KIND_TX_DONE;
    job.tx_offset = {off_clamp[10:1], 1'b0};
    job.pad_byte  = off_clamp[0];
    if (in_data.command) begin
      if (!tx_active_r) begin
        job.slots[SLOT_START] = 1'b1;
        tx_active_nxt         = 1'b1;
      end
    end else begin
      job.slots[SLOT_RX0] = 1'b1;
      if (in_data.a_ether_owned && in_data.b_ether_owned) begin
        job.rx0 = '{kind: KIND_RX_EMPTY, buffer_id: 1'b0, rx_length: 11'd0};
      end else if (in_data.a_ether_owned) begin
        job.rx0 = rx_serve(in_data.status_b, 1'b1);
      end else if (in_data.b_ether_owned) begin
        job.rx0 = rx_serve(in_data.status_a, 1'b0);
      end else if (in_data.b_older) begin
        job.slots[SLOT_RX1] = 1'b1;
        job.rx0 = rx_serve(in_data.status_b, 1'b1);
        job.rx1 = rx_serve(in_data.status_a, 1'b0);
      end else begin
        job.slots[SLOT_RX1] = 1'b1;
        job.rx0 = rx_serve(in_data.status_a, 1'b0);
        job.rx1 = rx_serve(in_data.status_b, 1'b1);
      end
      if (tx_active_r) begin
        if (in_data.jam_seen) begin
          job.slots[SLOT_TXEV] = 1'b1;
          if (mask_r == 16'd0) begin
            job.tx_kind           = KIND_TX_DROPPED;
            mask_nxt              = MASK_ALL_ONES;
            tx_active_nxt         = in_data.queue_pending;
            job.slots[SLOT_START] = in_data.queue_pending;
          end else begin
            job.tx_kind = KIND_TX_RETRY;
            mask_nxt    = mask_shift;
            job.delay   = in_data.time_low & ~mask_shift;
          end
        end else if (!in_data.tx_ether_owned) begin
          job.slots[SLOT_TXEV]  = 1'b1;
          job.tx_kind           = KIND_TX_DONE;
          mask_nxt              = MASK_ALL_ONES;
          tx_active_nxt         = in_data.queue_pending;
          job.slots[SLOT_START] = in_data.queue_pending;
        end
      end
    end
  end

  // a transmit request while busy leaves nothing to queue
  assign push = accept && (job.slots != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_active_r <= 1'b0;
      mask_r      <= MASK_ALL_ONES;
    end else if (accept) begin
      tx_active_r <= tx_active_nxt;
      mask_r      <= mask_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/dbes_queue.sv */
// short job queue between front and back end
`default_nettype none
module dbes_queue #(
  parameter int DEPTH = 2
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  dbes_pkg::job_t  push_job,
  input  wire             pop,
  output logic            full,
  output logic            head_valid,
  output dbes_pkg::job_t  head_job
);
  import dbes_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");

endmodule
`default_nettype wire

/* hdl/dbes_back.sv */
// back end: expands queued jobs into result items, one per cycle while out_stall does not hold the output
`default_nettype none
module dbes_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  head_valid,
  input  dbes_pkg::job_t       head_job,
  input  wire  [7:0]           slot_time,
  output logic                 pop,
  output logic                 out_valid,
  output dbes_pkg::out_item_t  out_data,
  input  wire                  out_stall
);
  import dbes_pkg::*;

  logic [NUM_SLOTS-1:0] done_r;
  logic [NUM_SLOTS-1:0] remain, sel, rest;
  logic                 advance, is_last;
  logic                 out_valid_r;
  out_item_t            out_r, out_nxt;
  logic [23:0]          product;

  assign remain  = head_job.slots & ~done_r;
  assign sel     = remain & (~remain + 1'b1);   // lowest pending slot
  assign rest    = remain & ~sel;
  assign is_last = (rest == '0);
  assign advance = head_valid && (!out_valid_r || !out_stall);
  assign pop     = advance && is_last;
  assign product = head_job.delay * slot_time;

  always_comb begin
    out_nxt      = '0;
    out_nxt.kind = KIND_RX_EMPTY;
    out_nxt.last = is_last;
    if (sel[SLOT_RX0]) begin
      out_nxt.kind      = head_job.rx0.kind;
      out_nxt.buffer_id = (head_job.rx0.kind == KIND_RX_EMPTY) ? 1'b0 : head_job.rx0.buffer_id;
      out_nxt.rx_length = head_job.rx0.rx_length;
    end else if (sel[SLOT_RX1]) begin
      out_nxt.kind      = head_job.rx1.kind;
      out_nxt.buffer_id = head_job.rx1.buffer_id;
      out_nxt.rx_length = head_job.rx1.rx_length;
    end else if (sel[SLOT_TXEV]) begin
      out_nxt.kind = head_job.tx_kind;
      if (head_job.tx_kind == KIND_TX_RETRY) begin
        out_nxt.backoff_value = product[15:0];
      end
    end else if (sel[SLOT_START]) begin
      out_nxt.kind      = KIND_TX_STARTED;
      out_nxt.tx_offset = head_job.tx_offset;
      out_nxt.pad_byte  = head_job.pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        done_r      <= is_last ? '0 : (done_r | sel);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* hdl/dual_buffer_ethernet_service.sv */
// top level of the dual buffer ethernet service block
`default_nettype none
// Serves a controller with two receive buffers and one transmit buffer. Each
// accepted item is either an interrupt event (serves host-owned receive
// buffers oldest first, then handles transmit done, collision backoff or drop,
// starting a pending transmit after done or drop) or a transmit request (computes
// the even frame start offset and pad flag). The front end takes one item per
// cycle whenever the job queue has room and updates the transmit state at once;
// the back end then emits that item's results, one to four of them, one per
// cycle while out_stall is low, through a single output register. A transmit
// request while a transmit is active gives no result. The first result reaches
// the output through the job queue and then the output register, and waits
// there while out_stall is high.
// Configuration: index 0 slot_time (8 bits), index 1 max_tx_offset (11 bits);
// write only while the block is idle. cfg_ready is always high.
module dual_buffer_ethernet_service #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // input items
  input  wire                  in_valid,
  input  dbes_pkg::in_item_t   in_data,
  output logic                 in_stall,
  // result items
  output logic                 out_valid,
  output dbes_pkg::out_item_t  out_data,
  input  wire                  out_stall,
  // configuration writes
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire                  cfg_index,
  input  wire  [10:0]          cfg_data
);
  import dbes_pkg::*;

  logic [7:0]  slot_time_r;
  logic [10:0] max_tx_offset_r;
  logic        q_full, q_push, q_pop, q_head_valid;
  job_t        q_push_job, q_head_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_time_r     <= SLOT_TIME_RST;
      max_tx_offset_r <= MAX_TX_OFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOT_TIME:     slot_time_r     <= cfg_data[7:0];
        CFG_MAX_TX_OFFSET: max_tx_offset_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // classify items and keep transmit state
  dbes_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .q_full        (q_full),
    .max_tx_offset (max_tx_offset_r),
    .push          (q_push),
    .job           (q_push_job)
  );

  // decouples acceptance from result delivery
  dbes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // result sequencing, backoff multiply and output register
  dbes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .slot_time  (slot_time_r),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule
`default_nettype wire
